// File: design/lsbds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbds_pkg
// shared types and constants of the line stop / backup drive sequencer
// ----------------------------------------------------------------------------
package lsbds_pkg;

    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned ENERGY_W = 48;
    localparam int unsigned ADD_W    = 26;   // 16 bit power times 10 bit period

    // command codes of the func field
    localparam logic [1:0] FUNC_TICK    = 2'd0;
    localparam logic [1:0] FUNC_ENABLE  = 2'd1;
    localparam logic [1:0] FUNC_DISABLE = 2'd2;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_SPEED  = 3'd0;
    localparam logic [2:0] REG_WAIT   = 3'd1;
    localparam logic [2:0] REG_BACKUP = 3'd2;
    localparam logic [2:0] REG_PAUSE  = 3'd3;
    localparam logic [2:0] REG_TICK   = 3'd4;

    // register reset values
    localparam logic [6:0]  SPEED_RST  = 7'd35;
    localparam logic [15:0] WAIT_RST   = 16'd1500;
    localparam logic [15:0] BACKUP_RST = 16'd2000;
    localparam logic [15:0] PAUSE_RST  = 16'd500;
    localparam logic [9:0]  TICK_RST   = 10'd50;

    localparam logic [6:0] SPEED_MAX = 7'd100;

    typedef struct packed {
        logic [6:0]  speed_pct;
        logic [15:0] line_hold_ms;
        logic [15:0] backup_ms;
        logic [15:0] pause_ms;
        logic [9:0]  tick_period_ms;
    } t_cfg;

    // one word as held in the input register
    typedef struct packed {
        logic [1:0]       func;
        logic [31:0]      now_ms;
        logic             line;
        logic             hall;
        logic [ADD_W-1:0] energy_add;
    } t_item;

    typedef struct packed {
        logic signed [7:0]   motor_left;
        logic signed [7:0]   motor_right;
        logic [2:0]          drive_state;
        logic                run_active;
        logic [31:0]         run_time_ms;
        logic [ENERGY_W-1:0] energy_mw_ms;
    } t_result;

endpackage

// File: design/line_stop_backup_drive_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_stop_backup_drive_sequencer
// vehicle drive sequencer: cruise, line wait, backup, pause and finish
// ----------------------------------------------------------------------------
// the word is held in the input register, and its result is registered in the output register when it moves on
// throughput: one word per cycle while the result is not stalled, set by the state update
// input register holds the word and its power x period product, output the result
// input stalls only while both registers are full and the result is stalled
// reset (synchronous, active low) clears the run state and loads the
// register defaults; no clearing pass, the block is ready the next cycle
module line_stop_backup_drive_sequencer
    import lsbds_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    // apb configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,

    // input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_func,
    input  logic [31:0]         i_now_ms,
    input  logic                i_line_front_left,
    input  logic                i_line_back_left,
    input  logic                i_line_back_right,
    input  logic                i_finish_hall,
    input  logic [15:0]         i_power_mw,

    // output channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [7:0]   o_motor_left,
    output logic signed [7:0]   o_motor_right,
    output logic [2:0]          o_drive_state,
    output logic                o_run_active,
    output logic [31:0]         o_run_time_ms,
    output logic [ENERGY_W-1:0] o_energy_mw_ms
);

    t_cfg    cfg;
    t_result core_result;

    // input register
    logic  r_in_valid;
    t_item r_in_item;

    // output register
    logic    r_out_valid;
    t_result r_out;

    logic accept;
    logic advance;

    lsbds_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // the held word moves into the output register when that register is
    // empty or its word is being taken this cycle
    assign advance = r_in_valid & (~r_out_valid | ~i_stall);
    assign o_stall = r_in_valid & ~advance;
    assign accept  = i_valid & ~o_stall;

    lsbds_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    // control of both stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept)       r_in_valid <= 1'b1;
            else if (advance) r_in_valid <= 1'b0;

            if (advance)       r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
        end
    end

    // payload, no reset; the energy product is formed here so the state
    // update only has the saturating add
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_item.func       <= i_func;
            r_in_item.now_ms     <= i_now_ms;
            r_in_item.line       <= i_line_front_left | i_line_back_left
                                    | i_line_back_right;
            r_in_item.hall       <= i_finish_hall;
            r_in_item.energy_add <= ADD_W'(i_power_mw) * ADD_W'(cfg.tick_period_ms);
        end
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_motor_left   = r_out.motor_left;
    assign o_motor_right  = r_out.motor_right;
    assign o_drive_state  = r_out.drive_state;
    assign o_run_active   = r_out.run_active;
    assign o_run_time_ms  = r_out.run_time_ms;
    assign o_energy_mw_ms = r_out.energy_mw_ms;

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with a free stage");

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result register empty after a word moved in");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> r_out_valid)
        else $error("stalled result dropped");

endmodule

// File: design/lsbds_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbds_cfg
// apb register file holding the five sequencer settings
// ----------------------------------------------------------------------------
module lsbds_cfg
    import lsbds_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_pct      <= SPEED_RST;
            r_cfg.line_hold_ms   <= WAIT_RST;
            r_cfg.backup_ms      <= BACKUP_RST;
            r_cfg.pause_ms       <= PAUSE_RST;
            r_cfg.tick_period_ms <= TICK_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SPEED:  r_cfg.speed_pct      <= pwdata[6:0];
                REG_WAIT:   r_cfg.line_hold_ms   <= pwdata[15:0];
                REG_BACKUP: r_cfg.backup_ms      <= pwdata[15:0];
                REG_PAUSE:  r_cfg.pause_ms       <= pwdata[15:0];
                REG_TICK:   r_cfg.tick_period_ms <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SPEED:  prdata = {25'd0, r_cfg.speed_pct};
            REG_WAIT:   prdata = {16'd0, r_cfg.line_hold_ms};
            REG_BACKUP: prdata = {16'd0, r_cfg.backup_ms};
            REG_PAUSE:  prdata = {16'd0, r_cfg.pause_ms};
            REG_TICK:   prdata = {22'd0, r_cfg.tick_period_ms};
            default:    prdata = '0;
        endcase
    end

endmodule

// File: design/lsbds_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbds_core
// drive mode state machine, run timer and energy accumulator
// ----------------------------------------------------------------------------
module lsbds_core
    import lsbds_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_CRUISE = 3'd1,
        MODE_WAIT   = 3'd2,
        MODE_BACKUP = 3'd3,
        MODE_PAUSE  = 3'd4,
        MODE_FINISH = 3'd5
    } t_mode;

    t_mode               r_mode,   n_mode;
    logic                r_en,     n_en;
    logic [31:0]         r_entry,  n_entry;
    logic [31:0]         r_start,  n_start;
    logic [31:0]         r_frozen, n_frozen;
    logic [ENERGY_W-1:0] r_energy, n_energy;
    logic [7:0]          r_left,   n_left;
    logic [7:0]          r_right,  n_right;

    logic [6:0]        fwd;
    logic [7:0]        fwd_cmd, rev_cmd;
    logic [31:0]       in_mode, run_time;
    logic [ENERGY_W:0] energy_sum;

    assign fwd        = (i_cfg.speed_pct > SPEED_MAX) ? SPEED_MAX : i_cfg.speed_pct;
    assign fwd_cmd    = {1'b0, fwd};
    assign rev_cmd    = 8'd0 - fwd_cmd;
    assign in_mode    = i_item.now_ms - r_entry;
    assign run_time   = i_item.now_ms - r_start;
    assign energy_sum = {1'b0, r_energy} + (ENERGY_W+1)'(i_item.energy_add);

    always_comb begin
        n_mode   = r_mode;
        n_en     = r_en;
        n_entry  = r_entry;
        n_start  = r_start;
        n_frozen = r_frozen;
        n_energy = r_energy;
        n_left   = r_left;
        n_right  = r_right;
        unique case (i_item.func)
            FUNC_TICK: begin
                if (!r_en) begin
                    if (r_mode != MODE_FINISH) n_mode = MODE_IDLE;
                    n_left  = '0;
                    n_right = '0;
                end else begin
                    n_energy = energy_sum[ENERGY_W] ? '1 : energy_sum[ENERGY_W-1:0];
                    if (r_mode != MODE_FINISH && i_item.hall) begin
                        n_left   = '0;
                        n_right  = '0;
                        n_mode   = MODE_FINISH;
                        n_entry  = i_item.now_ms;
                        n_frozen = run_time;
                        n_en     = 1'b0;
                    end else begin
                        unique case (r_mode)
                            MODE_IDLE: begin
                                n_mode  = MODE_CRUISE;
                                n_entry = i_item.now_ms;
                            end
                            MODE_CRUISE: begin
                                if (i_item.line) begin
                                    n_left  = '0;
                                    n_right = '0;
                                    n_mode  = MODE_WAIT;
                                    n_entry = i_item.now_ms;
                                end else begin
                                    n_left  = fwd_cmd;
                                    n_right = fwd_cmd;
                                end
                            end
                            MODE_WAIT: begin
                                n_left  = '0;
                                n_right = '0;
                                if (in_mode >= {16'd0, i_cfg.line_hold_ms}) begin
                                    n_mode  = MODE_BACKUP;
                                    n_entry = i_item.now_ms;
                                end
                            end
                            MODE_BACKUP: begin
                                if (in_mode < {16'd0, i_cfg.backup_ms}) begin
                                    n_left  = rev_cmd;
                                    n_right = rev_cmd;
                                end else begin
                                    n_left  = '0;
                                    n_right = '0;
                                    n_mode  = MODE_PAUSE;
                                    n_entry = i_item.now_ms;
                                end
                            end
                            MODE_PAUSE: begin
                                n_left  = '0;
                                n_right = '0;
                                if (in_mode >= {16'd0, i_cfg.pause_ms}) begin
                                    n_mode  = MODE_CRUISE;
                                    n_entry = i_item.now_ms;
                                end
                            end
                            default: begin
                                n_left  = '0;
                                n_right = '0;
                            end
                        endcase
                    end
                end
            end
            FUNC_ENABLE: begin
                n_mode   = MODE_CRUISE;
                n_entry  = i_item.now_ms;
                n_start  = i_item.now_ms;
                n_frozen = '0;
                n_energy = '0;
                n_en     = 1'b1;
            end
            FUNC_DISABLE: begin
                if (r_en) n_frozen = run_time;
                n_en    = 1'b0;
                n_left  = '0;
                n_right = '0;
                if (r_mode != MODE_FINISH) begin
                    n_mode  = MODE_IDLE;
                    n_entry = i_item.now_ms;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_en     <= 1'b0;
            r_entry  <= '0;
            r_start  <= '0;
            r_frozen <= '0;
            r_energy <= '0;
            r_left   <= '0;
            r_right  <= '0;
        end else if (i_step) begin
            r_mode   <= n_mode;
            r_en     <= n_en;
            r_entry  <= n_entry;
            r_start  <= n_start;
            r_frozen <= n_frozen;
            r_energy <= n_energy;
            r_left   <= n_left;
            r_right  <= n_right;
        end
    end

    // result reflects the state after this word
    always_comb begin
        o_result.motor_left   = n_left;
        o_result.motor_right  = n_right;
        o_result.drive_state  = n_mode;
        o_result.run_active   = n_en;
        o_result.run_time_ms  = n_en ? (i_item.now_ms - n_start) : n_frozen;
        o_result.energy_mw_ms = n_energy;
    end

    a_enabled_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_en |-> (r_mode != MODE_IDLE && r_mode != MODE_FINISH))
        else $error("enabled run in idle or finished mode");

    a_still_modes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_WAIT || r_mode == MODE_PAUSE || r_mode == MODE_FINISH)
        |-> (r_left == 8'd0 && r_right == 8'd0))
        else $error("motors running in a standstill mode");

    a_motors_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left == r_right)
        else $error("left and right motor commands differ");

    a_finish_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_mode == MODE_FINISH && i_item.func != FUNC_ENABLE)
        |=> (r_mode == MODE_FINISH))
        else $error("finished mode left without enable");

endmodule
